// ----- hdl/ffbs_pkg.sv -----
package ffbs_pkg;

    localparam int unsigned MAX_COLS_DEF    = 256;
    localparam int unsigned MAX_ROWS_DEF    = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 65536;

    localparam int unsigned COORD_W = 8;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned DIM_W   = 9;
    localparam int unsigned ENTRY_W = 2 * COORD_W;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned SUM_W   = 24;
    localparam int unsigned CEN_W   = 16;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned DVD_W   = SUM_W + FRAC_W;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FILL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [PIX_W-1:0]   pixel_value;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] left_edge;
        logic [COORD_W-1:0] right_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] bottom_edge;
        logic [CNT_W-1:0]   pixel_count;
        logic [SUM_W-1:0]   intensity_sum;
        logic [CEN_W-1:0]   centroid_col;
        logic [CEN_W-1:0]   centroid_row;
        logic               empty_blob;
        logic               queue_overflow;
    } result_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- hdl/ffbs_queue.sv -----
module ffbs_queue #(
    parameter int unsigned DEPTH = ffbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffbs_pkg::q_ctrl_t             ctrl,
    input  logic [ffbs_pkg::ENTRY_W-1:0]  push_data,
    output logic [ffbs_pkg::ENTRY_W-1:0]  rd_data,
    output ffbs_pkg::q_status_t           st
);
    import ffbs_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               push_en;
    logic               pop_en;

    assign st.empty = (count_reg == '0);
    assign st.full  = (count_reg == CW'(DEPTH));
    assign push_en  = ctrl.push && !st.full;
    assign pop_en   = ctrl.pop && !st.empty;
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (push_en)
            begin
                tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop_en)
            begin
                head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push_en && !pop_en)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (pop_en && !push_en)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && !ctrl.clear)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_data_reg <= mem[head_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        st.empty |-> !ctrl.pop)
        else $error("pop from empty queue");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> st.empty)
        else $error("queue not empty after clear");

endmodule

// ----- hdl/ffbs_div.sv -----
module ffbs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ffbs_pkg::DVD_W-1:0]  dividend,
    input  logic [ffbs_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [ffbs_pkg::CEN_W-1:0]  quotient
);
    import ffbs_pkg::*;

    localparam int unsigned STEP_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    shifted;
    logic              ge;

    assign shifted  = {rem_reg[CNT_W-1:0], dvd_reg[DVD_W-1]};
    assign ge       = (shifted >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = dvd_reg[CEN_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            rem_next  = ge ? (shifted - {1'b0, dsr_reg}) : shifted;
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ----- hdl/flood_fill_blob_stats.sv -----
// Channel  Ports                            Transaction
// command  start, busy, cmd                accepted when start is high and busy is low
// result   done, result                    valid for the single cycle done is high
// config   cfg_we, cfg_index, cfg_data      register written when cfg_we is high
//
// A pixel load leaves busy low, so loads can come every cycle while no fill runs.
// A fill reads the seed, then pops queue entries: one out of range or zero is
// skipped, one that joins the blob updates the statistics and checks its four
// neighbours one at a time over the single read port of the image memory. Both
// centroid divides run once the queue is empty; an empty seed ends at the seed step.
// Reset sets the control, configuration and statistics registers; the image memory is not cleared.
// The receiver cannot stall, so a result is shown for exactly one cycle.
module flood_fill_blob_stats #(
    parameter int unsigned MAX_COLS    = ffbs_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS    = ffbs_pkg::MAX_ROWS_DEF,
    parameter int unsigned QUEUE_DEPTH = ffbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ffbs_pkg::cmd_t                 cmd,
    input  logic                           cfg_we,
    input  logic [ffbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffbs_pkg::CFG_W-1:0]     cfg_data,
    output logic                           done,
    output ffbs_pkg::result_t              result
);
    import ffbs_pkg::*;

    localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned EW_CAP      = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int unsigned EH_CAP      = (MAX_ROWS < 256) ? MAX_ROWS : 256;

    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_DOWN  = 2'd2;
    localparam logic [1:0] NB_UP    = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SEED  = 8'b0000_0010,
        S_POP   = 8'b0000_0100,
        S_QWAIT = 8'b0000_1000,
        S_CUR   = 8'b0001_0000,
        S_NB    = 8'b0010_0000,
        S_DIVC  = 8'b0100_0000,
        S_DIVR  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic             ok;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
    } nbr_t;

    function automatic logic [ADDR_W-1:0] pix_addr(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y);
        logic [31:0] lin;
        lin = 32'(y) * 32'(MAX_COLS) + 32'(x);
        return lin[ADDR_W-1:0];
    endfunction

    function automatic nbr_t nbr_of(logic [1:0] k, logic [COORD_W-1:0] cx,
                                    logic [COORD_W-1:0] cy, logic [DIM_W-1:0] ew,
                                    logic [DIM_W-1:0] eh);
        nbr_t n;
        n.x  = {1'b0, cx};
        n.y  = {1'b0, cy};
        n.ok = 1'b1;
        case (k)
            NB_RIGHT: n.x = {1'b0, cx} + 9'd1;
            NB_LEFT:
            begin
                n.x  = {1'b0, cx} - 9'd1;
                n.ok = (cx != '0);
            end
            NB_DOWN:  n.y = {1'b0, cy} + 9'd1;
            NB_UP:
            begin
                n.y  = {1'b0, cy} - 9'd1;
                n.ok = (cy != '0);
            end
            default: n.ok = 1'b0;
        endcase
        n.ok = n.ok && (n.x < ew) && (n.y < eh);
        return n;
    endfunction

    logic [PIX_W-1:0] img_mem [STORE_DEPTH];
    logic [PIX_W-1:0] img_rd_reg;
    logic [ADDR_W-1:0] img_raddr;
    logic [ADDR_W-1:0] img_waddr;
    logic [PIX_W-1:0]  img_wdata;
    logic              img_we;

    state_t state_reg, state_next;
    logic [PIX_W-1:0]   bmin_reg;
    logic [DIM_W-1:0]   wid_reg;
    logic [DIM_W-1:0]   hgt_reg;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [1:0]         nb_k_reg, nb_k_next;
    logic               seed_ok_reg, seed_ok_next;
    logic [COORD_W-1:0] min_c_reg, min_c_next;
    logic [COORD_W-1:0] max_c_reg, max_c_next;
    logic [COORD_W-1:0] min_r_reg, min_r_next;
    logic [COORD_W-1:0] max_r_reg, max_r_next;
    logic [SUM_W-1:0]   sum_c_reg, sum_c_next;
    logic [SUM_W-1:0]   sum_r_reg, sum_r_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   bright_reg, bright_next;
    logic               ovf_reg, ovf_next;
    logic               empty_reg, empty_next;
    logic [CEN_W-1:0]   cen_c_reg, cen_c_next;
    result_t            result_reg, result_next;
    logic               done_reg, done_next;

    logic [DIM_W-1:0]   ew;
    logic [DIM_W-1:0]   eh;
    logic [PIX_W-1:0]   thr;
    nbr_t               nb_chk;
    nbr_t               nb_iss;
    logic [1:0]         nb_iss_k;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;

    q_ctrl_t            q_ctrl;
    q_status_t          q_st;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_rd_data;

    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic               div_done;
    logic [CEN_W-1:0]   div_quot;

    assign ew = (32'(wid_reg) > EW_CAP) ? DIM_W'(EW_CAP) : wid_reg;
    assign eh = (32'(hgt_reg) > EH_CAP) ? DIM_W'(EH_CAP) : hgt_reg;
    assign thr = (bmin_reg == '0) ? PIX_W'(1) : bmin_reg;
    assign qx = q_rd_data[COORD_W-1:0];
    assign qy = q_rd_data[ENTRY_W-1:COORD_W];
    assign nb_iss_k = (state_reg == S_CUR) ? NB_RIGHT : nb_k_reg + 2'd1;
    assign nb_chk = nbr_of(nb_k_reg, cx_reg, cy_reg, ew, eh);
    assign nb_iss = nbr_of(nb_iss_k, cx_reg, cy_reg, ew, eh);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    ffbs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .push_data(q_push_data),
        .rd_data  (q_rd_data),
        .st       (q_st)
    );

    ffbs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (count_reg),
        .done    (div_done),
        .quotient(div_quot)
    );

    always_comb
    begin
        state_next   = state_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        nb_k_next    = nb_k_reg;
        seed_ok_next = seed_ok_reg;
        min_c_next   = min_c_reg;
        max_c_next   = max_c_reg;
        min_r_next   = min_r_reg;
        max_r_next   = max_r_reg;
        sum_c_next   = sum_c_reg;
        sum_r_next   = sum_r_reg;
        count_next   = count_reg;
        bright_next  = bright_reg;
        ovf_next     = ovf_reg;
        empty_next   = empty_reg;
        cen_c_next   = cen_c_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        img_raddr    = pix_addr(nb_iss.x, nb_iss.y);
        img_waddr    = pix_addr({1'b0, cx_reg}, {1'b0, cy_reg});
        img_wdata    = '0;
        img_we       = 1'b0;
        q_ctrl       = '0;
        q_push_data  = {cy_reg, cx_reg};
        div_start    = 1'b0;
        div_dividend = {sum_c_reg, FRAC_W'(0)};

        result_next.left_edge      = min_c_reg;
        result_next.right_edge     = max_c_reg;
        result_next.top_edge       = min_r_reg;
        result_next.bottom_edge    = max_r_reg;
        result_next.pixel_count    = count_reg;
        result_next.intensity_sum  = bright_reg;
        result_next.centroid_col   = '0;
        result_next.centroid_row   = '0;
        result_next.empty_blob     = empty_reg;
        result_next.queue_overflow = ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                img_raddr = pix_addr({1'b0, cmd.pos_x}, {1'b0, cmd.pos_y});
                img_waddr = pix_addr({1'b0, cmd.pos_x}, {1'b0, cmd.pos_y});
                img_wdata = cmd.pixel_value;
                result_next = result_reg;
                if (start)
                begin
                    if (cmd.opcode == OP_LOAD)
                    begin
                        img_we = (32'(cmd.pos_x) < MAX_COLS) && (32'(cmd.pos_y) < MAX_ROWS);
                    end
                    else
                    begin
                        cx_next      = cmd.pos_x;
                        cy_next      = cmd.pos_y;
                        seed_ok_next = ({1'b0, cmd.pos_x} < ew) && ({1'b0, cmd.pos_y} < eh);
                        min_c_next   = '0;
                        max_c_next   = '0;
                        min_r_next   = '0;
                        max_r_next   = '0;
                        sum_c_next   = '0;
                        sum_r_next   = '0;
                        count_next   = '0;
                        bright_next  = '0;
                        ovf_next     = 1'b0;
                        empty_next   = 1'b0;
                        q_ctrl.clear = 1'b1;
                        state_next   = S_SEED;
                    end
                end
            end
            S_SEED:
            begin
                if (seed_ok_reg && (img_rd_reg != '0))
                begin
                    q_ctrl.push = 1'b1;
                    state_next  = S_POP;
                end
                else
                begin
                    result_next.empty_blob = 1'b1;
                    empty_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (!q_st.empty)
                begin
                    q_ctrl.pop = 1'b1;
                    state_next = S_QWAIT;
                end
                else if (count_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVC;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QWAIT:
            begin
                cx_next    = qx;
                cy_next    = qy;
                img_raddr  = pix_addr({1'b0, qx}, {1'b0, qy});
                state_next = S_CUR;
            end
            S_CUR:
            begin
                if (({1'b0, cx_reg} < ew) && ({1'b0, cy_reg} < eh) && (img_rd_reg != '0))
                begin
                    img_we      = 1'b1;
                    count_next  = count_reg + 1'b1;
                    bright_next = bright_reg + SUM_W'(img_rd_reg);
                    sum_c_next  = sum_c_reg + SUM_W'(cx_reg);
                    sum_r_next  = sum_r_reg + SUM_W'(cy_reg);
                    if (count_reg == '0)
                    begin
                        min_c_next = cx_reg;
                        max_c_next = cx_reg;
                        min_r_next = cy_reg;
                        max_r_next = cy_reg;
                    end
                    else
                    begin
                        min_c_next = (cx_reg < min_c_reg) ? cx_reg : min_c_reg;
                        max_c_next = (cx_reg > max_c_reg) ? cx_reg : max_c_reg;
                        min_r_next = (cy_reg < min_r_reg) ? cy_reg : min_r_reg;
                        max_r_next = (cy_reg > max_r_reg) ? cy_reg : max_r_reg;
                    end
                    nb_k_next  = NB_RIGHT;
                    state_next = S_NB;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_NB:
            begin
                q_push_data = {nb_chk.y[COORD_W-1:0], nb_chk.x[COORD_W-1:0]};
                if (nb_chk.ok && (img_rd_reg >= thr))
                begin
                    q_ctrl.push = 1'b1;
                    if (q_st.full)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (nb_k_reg == NB_UP)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    nb_k_next = nb_k_reg + 2'd1;
                end
            end
            S_DIVC:
            begin
                div_dividend = {sum_r_reg, FRAC_W'(0)};
                if (div_done)
                begin
                    cen_c_next = div_quot;
                    div_start  = 1'b1;
                    state_next = S_DIVR;
                end
            end
            S_DIVR:
            begin
                if (div_done)
                begin
                    result_next.centroid_col = cen_c_reg;
                    result_next.centroid_row = div_quot;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            bmin_reg   <= PIX_W'(1);
            wid_reg    <= DIM_W'(256);
            hgt_reg    <= DIM_W'(256);
            min_c_reg  <= '0;
            max_c_reg  <= '0;
            min_r_reg  <= '0;
            max_r_reg  <= '0;
            sum_c_reg  <= '0;
            sum_r_reg  <= '0;
            count_reg  <= '0;
            bright_reg <= '0;
            ovf_reg    <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            min_c_reg  <= min_c_next;
            max_c_reg  <= max_c_next;
            min_r_reg  <= min_r_next;
            max_r_reg  <= max_r_next;
            sum_c_reg  <= sum_c_next;
            sum_r_reg  <= sum_r_next;
            count_reg  <= count_next;
            bright_reg <= bright_next;
            ovf_reg    <= ovf_next;
            empty_reg  <= empty_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BRIGHTNESS_MIN: bmin_reg <= cfg_data[PIX_W-1:0];
                    CFG_IMAGE_WIDTH:    wid_reg  <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:   hgt_reg  <= cfg_data[DIM_W-1:0];
                    default:            bmin_reg <= bmin_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        nb_k_reg    <= nb_k_next;
        seed_ok_reg <= seed_ok_next;
        cen_c_reg   <= cen_c_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= img_wdata;
        end
        img_rd_reg <= img_mem[img_raddr];
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a fill is still running");
    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_FILL) |=> busy)
        else $error("fill transaction did not raise busy");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.empty_blob) |-> (result.pixel_count == '0))
        else $error("empty blob reports pixels");

endmodule

// ----- test/flood_fill_blob_stats_checker.sv -----
module flood_fill_blob_stats_checker
    import ffbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 done,
    input  result_t              result,
    output int                   errors,
    output int                   pending
);

    logic [PIX_W-1:0] pixels [65536];
    logic [7:0]       thr_reg;
    logic [8:0]       width_reg;
    logic [8:0]       height_reg;
    result_t          blob_q [$];
    int               search_q [$];
    bit               dropped;
    int               area_w;
    int               area_h;
    int               thr;

    function automatic void try_push(int x, int y);
        if (x < area_w && y < area_h && pixels[y * 256 + x] >= thr)
        begin
            if (search_q.size() >= QUEUE_DEPTH_DEF)
                dropped = 1'b1;
            else
                search_q.push_back(y * 256 + x);
        end
    endfunction

    function automatic result_t blob_stats(int sx, int sy);
        result_t r;
        int e;
        int cx;
        int cy;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] bsum;
        logic [SUM_W-1:0] csum;
        logic [SUM_W-1:0] rsum;
        logic [DVD_W-1:0] quo;
        r = '0;
        cnt = '0;
        bsum = '0;
        csum = '0;
        rsum = '0;
        area_w = width_reg > 256 ? 256 : int'(width_reg);
        area_h = height_reg > 256 ? 256 : int'(height_reg);
        thr = thr_reg == 0 ? 1 : int'(thr_reg);
        dropped = 1'b0;
        search_q.delete();
        if (!(sx < area_w && sy < area_h && pixels[sy * 256 + sx] != 0))
        begin
            r.empty_blob = 1'b1;
            return r;
        end
        search_q.push_back(sy * 256 + sx);
        while (search_q.size() > 0)
        begin
            e = search_q.pop_front();
            cx = e % 256;
            cy = e / 256;
            if (cx >= area_w || cy >= area_h || pixels[e] == 0)
                continue;
            if (cx < 255)
                try_push(cx + 1, cy);
            if (cx > 0)
                try_push(cx - 1, cy);
            if (cy < 255)
                try_push(cx, cy + 1);
            if (cy > 0)
                try_push(cx, cy - 1);
            if (cnt == 0)
            begin
                r.left_edge = COORD_W'(cx);
                r.right_edge = COORD_W'(cx);
                r.top_edge = COORD_W'(cy);
                r.bottom_edge = COORD_W'(cy);
            end
            else
            begin
                if (cx < r.left_edge)
                    r.left_edge = COORD_W'(cx);
                if (cx > r.right_edge)
                    r.right_edge = COORD_W'(cx);
                if (cy < r.top_edge)
                    r.top_edge = COORD_W'(cy);
                if (cy > r.bottom_edge)
                    r.bottom_edge = COORD_W'(cy);
            end
            bsum = bsum + SUM_W'(pixels[e]);
            csum = csum + SUM_W'(cx);
            rsum = rsum + SUM_W'(cy);
            cnt = cnt + 1'b1;
            pixels[e] = '0;
        end
        r.pixel_count = cnt;
        r.intensity_sum = bsum;
        if (cnt != 0)
        begin
            quo = {csum, 8'b0} / cnt;
            r.centroid_col = quo[CEN_W-1:0];
            quo = {rsum, 8'b0} / cnt;
            r.centroid_row = quo[CEN_W-1:0];
        end
        r.queue_overflow = dropped;
        return r;
    endfunction

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            thr_reg    = 8'd1;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            errors     = 0;
        end
        else
        begin
            if (done)
            begin
                if (blob_q.size() == 0)
                begin
                    $error("result transaction with no fill outstanding");
                    errors++;
                end
                else
                begin
                    want = blob_q.pop_front();
                    check_field("left_edge", want.left_edge, result.left_edge);
                    check_field("right_edge", want.right_edge, result.right_edge);
                    check_field("top_edge", want.top_edge, result.top_edge);
                    check_field("bottom_edge", want.bottom_edge, result.bottom_edge);
                    check_field("pixel_count", want.pixel_count, result.pixel_count);
                    check_field("intensity_sum", want.intensity_sum, result.intensity_sum);
                    check_field("centroid_col", want.centroid_col, result.centroid_col);
                    check_field("centroid_row", want.centroid_row, result.centroid_row);
                    check_field("empty_blob", want.empty_blob, result.empty_blob);
                    check_field("queue_overflow", want.queue_overflow,
                                result.queue_overflow);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BRIGHTNESS_MIN: thr_reg = cfg_data[7:0];
                    CFG_IMAGE_WIDTH:    width_reg = cfg_data;
                    CFG_IMAGE_HEIGHT:   height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (cmd.opcode == OP_LOAD)
                    pixels[cmd.pos_y * 256 + cmd.pos_x] = cmd.pixel_value;
                else
                    blob_q.push_back(blob_stats(cmd.pos_x, cmd.pos_y));
            end
        end
        pending = blob_q.size();
    end

endmodule

// ----- test/flood_fill_blob_stats_test.sv -----
module flood_fill_blob_stats_test;
    import ffbs_pkg::*;

    localparam int CORE = 20;
    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    result_t              result;
    int                   errors;
    int                   pending;
    int                   cycles;
    int                   idle_pct;
    int                   area_w;
    int                   area_h;
    bit                   written [65536];

    flood_fill_blob_stats i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    flood_fill_blob_stats_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL flood_fill_blob_stats");
            $finish;
        end
    end

    task automatic issue(logic op, int x, int y, int v);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        start = 1'b1;
        cmd.opcode = op;
        cmd.pos_x = COORD_W'(x);
        cmd.pos_y = COORD_W'(y);
        cmd.pixel_value = PIX_W'(v);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic bit is_written(int x, int y);
        if (x < 0 || y < 0 || x > 255 || y > 255)
            return 1'b1;
        return written[y * 256 + x];
    endfunction

    // A nonzero pixel must have every neighbor already loaded, so a fill never
    // reads a location that has not been written since power-up.
    task automatic put_pixel(int x, int y, int v);
        if (!(is_written(x + 1, y) && is_written(x - 1, y) &&
              is_written(x, y + 1) && is_written(x, y - 1)))
            v = 0;
        written[y * 256 + x] = 1'b1;
        issue(OP_LOAD, x, y, v);
    endtask

    task automatic fill_at(int x, int y);
        if (x < area_w && y < area_h && !written[y * 256 + x])
        begin
            x = $urandom_range(CORE - 1);
            y = $urandom_range(CORE - 1);
        end
        issue(OP_FILL, x, y, $urandom_range(255));
    endtask

    task automatic drain();
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_mode(int thr, int w, int h);
        drain();
        write_reg(CFG_BRIGHTNESS_MIN, thr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        area_w = w > 256 ? 256 : w;
        area_h = h > 256 ? 256 : h;
    endtask

    task automatic random_items(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            if ($urandom_range(99) < 45)
            begin
                if ($urandom_range(99) < 80)
                    fill_at($urandom_range(CORE - 1), $urandom_range(CORE - 1));
                else
                    fill_at($urandom_range(255), $urandom_range(255));
            end
            else if ($urandom_range(99) < 85)
                put_pixel($urandom_range(CORE - 1), $urandom_range(CORE - 1),
                          $urandom_range(99) < 70 ? $urandom_range(255, 1) : 0);
            else
                put_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial
    begin
        int thr_set [6] = '{1, 0, 255, 128, 50, 1};
        int w_set [6] = '{256, 19, 1, 10, 511, 256};
        int h_set [6] = '{256, 19, 1, 256, 0, 7};
        int idle_set [6] = '{0, 71, 0, 30, 71, 30};
        idle_pct = 0;
        area_w = 256;
        area_h = 256;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int y = 0; y <= CORE; y++)
            for (int x = 0; x <= CORE; x++)
                put_pixel(x, y, 0);

        // Corner pixels at both ends of the coordinate range, then a row of rising values on row 3.
        put_pixel(254, 255, 0);
        put_pixel(255, 254, 0);
        put_pixel(255, 255, 255);
        fill_at(255, 255);
        fill_at(255, 255);
        put_pixel(0, 0, 1);
        put_pixel(1, 0, 255);
        put_pixel(0, 1, 7);
        put_pixel(1, 1, 200);
        fill_at(0, 0);
        fill_at(5, 5);
        for (int x = 2; x < 12; x++)
            put_pixel(x, 3, x * 20);
        fill_at(11, 3);

        for (int p = 0; p < 6; p++)
        begin
            set_mode(thr_set[p], w_set[p], h_set[p]);
            idle_pct = idle_set[p];
            random_items(180);
        end

        idle_pct = 0;
        drain();
        if (errors == 0)
            $display("PASS flood_fill_blob_stats");
        else
            $display("FAIL flood_fill_blob_stats");
        $finish;
    end

endmodule
